// ===== hw/rtl/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Shared constants, microcode types and the control store of the prime lister.
// ----------------------------------------------------------------------------
package plt_pkg;

  // Sizes of the prime table and of the values it holds
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned VAL_W       = 9;
  localparam int unsigned SQ_W        = 2 * VAL_W;
  localparam int unsigned STEP_W      = $clog2(VAL_W + 1);
  localparam int unsigned PC_W        = 5;

  localparam logic [VAL_W-1:0] MAX_LIMIT  = VAL_W'(311);
  localparam logic [VAL_W-1:0] FIRST_CAND = VAL_W'(5);
  localparam logic [VAL_W-1:0] SEED_TWO   = VAL_W'(2);
  localparam logic [VAL_W-1:0] SEED_THREE = VAL_W'(3);

  // Datapath operation carried by each control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SEED0,
    OP_SEED1,
    OP_IDX1,
    OP_READ,
    OP_SQUARE,
    OP_REM_START,
    OP_INC_IDX,
    OP_APPEND,
    OP_NEXT_CAND,
    OP_SHOW
  } op_e;

  // Jump condition carried by each control word
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CAND_DONE,
    COND_IDX_END,
    COND_SQ_GT,
    COND_REM_BUSY,
    COND_REM_ZERO,
    COND_LIM_LT3,
    COND_OUT_BUSY,
    COND_LAST
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Flags the datapath hands back to the sequencer
  typedef struct packed {
    logic cand_done;
    logic idx_end;
    logic sq_gt;
    logic rem_busy;
    logic rem_zero;
    logic lim_lt3;
    logic out_busy;
    logic last;
  } status_t;

  // Step addresses of the program
  localparam logic [PC_W-1:0] UA_IDLE     = PC_W'(0);
  localparam logic [PC_W-1:0] UA_SEED0    = PC_W'(1);
  localparam logic [PC_W-1:0] UA_SEED1    = PC_W'(2);
  localparam logic [PC_W-1:0] UA_CHECK    = PC_W'(3);
  localparam logic [PC_W-1:0] UA_DIV_RD   = PC_W'(4);
  localparam logic [PC_W-1:0] UA_SQUARE   = PC_W'(5);
  localparam logic [PC_W-1:0] UA_SQ_TEST  = PC_W'(6);
  localparam logic [PC_W-1:0] UA_REM_WAIT = PC_W'(7);
  localparam logic [PC_W-1:0] UA_REM_TEST = PC_W'(8);
  localparam logic [PC_W-1:0] UA_INC_DIV  = PC_W'(9);
  localparam logic [PC_W-1:0] UA_APPEND   = PC_W'(10);
  localparam logic [PC_W-1:0] UA_NEXT     = PC_W'(11);
  localparam logic [PC_W-1:0] UA_EMIT     = PC_W'(12);
  localparam logic [PC_W-1:0] UA_OUT_RD   = PC_W'(13);
  localparam logic [PC_W-1:0] UA_OUT_WAIT = PC_W'(14);
  localparam logic [PC_W-1:0] UA_SHOW     = PC_W'(15);
  localparam logic [PC_W-1:0] UA_OUT_INC  = PC_W'(16);
  localparam logic [PC_W-1:0] UA_OUT_LOOP = PC_W'(17);

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    case (pc)
      UA_IDLE:     uw = '{OP_ACCEPT,    COND_NO_INPUT,  UA_IDLE};
      UA_SEED0:    uw = '{OP_SEED0,     COND_NEVER,     UA_IDLE};
      UA_SEED1:    uw = '{OP_SEED1,     COND_NEVER,     UA_IDLE};
      UA_CHECK:    uw = '{OP_IDX1,      COND_CAND_DONE, UA_EMIT};
      UA_DIV_RD:   uw = '{OP_READ,      COND_IDX_END,   UA_APPEND};
      UA_SQUARE:   uw = '{OP_SQUARE,    COND_NEVER,     UA_IDLE};
      UA_SQ_TEST:  uw = '{OP_REM_START, COND_SQ_GT,     UA_APPEND};
      UA_REM_WAIT: uw = '{OP_NOP,       COND_REM_BUSY,  UA_REM_WAIT};
      UA_REM_TEST: uw = '{OP_NOP,       COND_REM_ZERO,  UA_NEXT};
      UA_INC_DIV:  uw = '{OP_INC_IDX,   COND_ALWAYS,    UA_DIV_RD};
      UA_APPEND:   uw = '{OP_APPEND,    COND_NEVER,     UA_IDLE};
      UA_NEXT:     uw = '{OP_NEXT_CAND, COND_ALWAYS,    UA_CHECK};
      UA_EMIT:     uw = '{OP_IDX1,      COND_LIM_LT3,   UA_IDLE};
      UA_OUT_RD:   uw = '{OP_READ,      COND_NEVER,     UA_IDLE};
      UA_OUT_WAIT: uw = '{OP_NOP,       COND_OUT_BUSY,  UA_OUT_WAIT};
      UA_SHOW:     uw = '{OP_SHOW,      COND_NEVER,     UA_IDLE};
      UA_OUT_INC:  uw = '{OP_INC_IDX,   COND_LAST,      UA_IDLE};
      UA_OUT_LOOP: uw = '{OP_NOP,       COND_ALWAYS,    UA_OUT_RD};
      default:     uw = '{OP_NOP,       COND_ALWAYS,    UA_IDLE};
    endcase
    return uw;
  endfunction

endpackage

// ===== hw/rtl/plt_ram.sv =====
// ----------------------------------------------------------------------------
// plt_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/plt_rem.sv =====
// ----------------------------------------------------------------------------
// plt_rem
// Restoring remainder unit: one quotient bit per cycle, flags a zero remainder.
// ----------------------------------------------------------------------------
module plt_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [plt_pkg::VAL_W-1:0] dividend_i,
  input  logic [plt_pkg::VAL_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      rem_zero_o
);

  logic                       busy_q, busy_d;
  logic [plt_pkg::STEP_W-1:0] step_q, step_d;
  logic [plt_pkg::VAL_W-1:0]  num_q, num_d;
  logic [plt_pkg::VAL_W-1:0]  den_q, den_d;
  logic [plt_pkg::VAL_W-1:0]  rem_q, rem_d;
  logic [plt_pkg::VAL_W:0]    trial;
  logic [plt_pkg::VAL_W:0]    diff;

  // Shift in the next dividend bit and subtract where it fits
  assign trial = {rem_q, num_q[plt_pkg::VAL_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = plt_pkg::STEP_W'(plt_pkg::VAL_W);
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d  = {num_q[plt_pkg::VAL_W-2:0], 1'b0};
      rem_d  = (trial >= {1'b0, den_q}) ? diff[plt_pkg::VAL_W-1:0]
                                         : trial[plt_pkg::VAL_W-1:0];
      step_d = step_q - plt_pkg::STEP_W'(1);
      busy_d = (step_q != plt_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Operands need no reset
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

// ===== hw/rtl/plt_dp.sv =====
// ----------------------------------------------------------------------------
// plt_dp
// Datapath: limit, candidate and index registers, prime table, squarer,
// remainder unit and the output register, all steered by the control word.
// ----------------------------------------------------------------------------
module plt_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  plt_pkg::op_e              op_i,
  input  logic                      in_valid_i,
  input  logic [plt_pkg::VAL_W-1:0] limit_i,
  input  logic                      out_ready_i,
  output plt_pkg::status_t          status_o,
  output logic                      out_valid_o,
  output logic [plt_pkg::VAL_W-1:0] prime_value_o,
  output logic                      last_o
);

  logic [plt_pkg::VAL_W-1:0]  lim_q, lim_d;
  logic [plt_pkg::VAL_W-1:0]  cand_q, cand_d;
  logic [plt_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [plt_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic [plt_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic                       out_valid_q, out_valid_d;
  logic [plt_pkg::VAL_W-1:0]  prime_q, prime_d;
  logic                       last_q, last_d;

  logic                       ram_we;
  logic [plt_pkg::ADDR_W-1:0] ram_waddr;
  logic [plt_pkg::VAL_W-1:0]  ram_wdata;
  logic                       ram_re;
  logic [plt_pkg::VAL_W-1:0]  ram_rdata;
  logic [plt_pkg::SQ_W-1:0]   q_wide;
  logic [plt_pkg::CNT_W-1:0]  idx_next;
  logic                       is_last;
  logic                       rem_busy;
  logic                       rem_zero;

  assign q_wide   = {{plt_pkg::VAL_W{1'b0}}, ram_rdata};
  assign idx_next = idx_q + plt_pkg::CNT_W'(1);
  assign is_last  = (idx_next >= cnt_q);

  // Table write port: seeds and appended primes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q[plt_pkg::ADDR_W-1:0];
    ram_wdata = cand_q;
    case (op_i)
      plt_pkg::OP_SEED0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = plt_pkg::SEED_TWO;
      end
      plt_pkg::OP_SEED1: begin
        ram_we    = 1'b1;
        ram_waddr = plt_pkg::ADDR_W'(1);
        ram_wdata = plt_pkg::SEED_THREE;
      end
      plt_pkg::OP_APPEND: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_re = (op_i == plt_pkg::OP_READ);

  plt_ram #(
    .WIDTH (plt_pkg::VAL_W),
    .DEPTH (plt_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[plt_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  plt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op_i == plt_pkg::OP_REM_START),
    .dividend_i (cand_q),
    .divisor_i  (ram_rdata),
    .busy_o     (rem_busy),
    .rem_zero_o (rem_zero)
  );

  // Register updates per operation
  always_comb begin
    lim_d       = lim_q;
    cand_d      = cand_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sq_d        = sq_q;
    out_valid_d = out_valid_q;
    prime_d     = prime_q;
    last_d      = last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (op_i)
      plt_pkg::OP_ACCEPT: begin
        if (in_valid_i) begin
          lim_d = (limit_i > plt_pkg::MAX_LIMIT) ? plt_pkg::MAX_LIMIT : limit_i;
        end
      end
      plt_pkg::OP_SEED1: begin
        cnt_d  = plt_pkg::CNT_W'(2);
        cand_d = plt_pkg::FIRST_CAND;
      end
      plt_pkg::OP_IDX1: begin
        idx_d = plt_pkg::CNT_W'(1);
      end
      plt_pkg::OP_SQUARE: begin
        sq_d = q_wide * q_wide;
      end
      plt_pkg::OP_INC_IDX: begin
        idx_d = idx_next;
      end
      plt_pkg::OP_APPEND: begin
        cnt_d = cnt_q + plt_pkg::CNT_W'(1);
      end
      plt_pkg::OP_NEXT_CAND: begin
        cand_d = cand_q + plt_pkg::VAL_W'(2);
      end
      plt_pkg::OP_SHOW: begin
        out_valid_d = 1'b1;
        prime_d     = ram_rdata;
        last_d      = is_last;
      end
      default: begin
        lim_d = lim_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cand_q      <= cand_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lim_q   <= lim_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    last_q  <= last_d;
  end

  // Flags for the sequencer
  assign status_o.cand_done = (cand_q > lim_q) ||
                              (cnt_q >= plt_pkg::CNT_W'(plt_pkg::TABLE_DEPTH));
  assign status_o.idx_end   = (idx_q >= cnt_q);
  assign status_o.sq_gt     = (sq_q > {{plt_pkg::VAL_W{1'b0}}, cand_q});
  assign status_o.rem_busy  = rem_busy;
  assign status_o.rem_zero  = rem_zero;
  assign status_o.lim_lt3   = (lim_q < plt_pkg::SEED_THREE);
  assign status_o.out_busy  = out_valid_q;
  assign status_o.last      = is_last;

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = prime_q;
  assign last_o        = last_q;

endmodule

// ===== hw/rtl/plt_ctrl.sv =====
// ----------------------------------------------------------------------------
// plt_ctrl
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module plt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  plt_pkg::status_t status_i,
  output plt_pkg::op_e     op_o
);

  logic [plt_pkg::PC_W-1:0] pc_q, pc_d;
  plt_pkg::ucode_t          uw;
  logic                     take;

  assign uw = plt_pkg::ucode_rom(pc_q);

  // Evaluate the jump condition of the current word
  always_comb begin
    case (uw.cond)
      plt_pkg::COND_NEVER:     take = 1'b0;
      plt_pkg::COND_ALWAYS:    take = 1'b1;
      plt_pkg::COND_NO_INPUT:  take = !in_valid_i;
      plt_pkg::COND_CAND_DONE: take = status_i.cand_done;
      plt_pkg::COND_IDX_END:   take = status_i.idx_end;
      plt_pkg::COND_SQ_GT:     take = status_i.sq_gt;
      plt_pkg::COND_REM_BUSY:  take = status_i.rem_busy;
      plt_pkg::COND_REM_ZERO:  take = status_i.rem_zero;
      plt_pkg::COND_LIM_LT3:   take = status_i.lim_lt3;
      plt_pkg::COND_OUT_BUSY:  take = status_i.out_busy;
      plt_pkg::COND_LAST:      take = status_i.last;
      default:                 take = 1'b1;
    endcase
  end

  // Jump or advance
  assign pc_d = take ? uw.target : pc_q + plt_pkg::PC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= plt_pkg::UA_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uw.op;

endmodule

// ===== hw/rtl/prime_list_trial_division.sv =====
// Each trial divisor is read and squared; while its square does not exceed the
// candidate, the remainder unit divides it into the candidate. Results leave
// one prime at a time, the next only once the last one has been taken.
// One request at a time; the next is taken once the last prime is registered.
// Reset clears the sequencer and output valid; the prime table is rebuilt on
// every request and needs no clearing.
// ----------------------------------------------------------------------------
// prime_list_trial_division
// Lists the odd primes up to a requested limit by trial division against a
// table of earlier primes, under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
module prime_list_trial_division (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [plt_pkg::VAL_W-1:0] limit_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [plt_pkg::VAL_W-1:0] prime_value_o,
  output logic                      last_o
);

  plt_pkg::op_e     op;
  plt_pkg::status_t status;

  plt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .op_o       (op)
  );

  plt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .in_valid_i    (in_valid_i),
    .limit_i       (limit_i),
    .out_ready_i   (out_ready_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .prime_value_o (prime_value_o),
    .last_o        (last_o)
  );

  // Take a request only in the waiting step
  assign in_ready_o = (op == plt_pkg::OP_ACCEPT);

endmodule

// ===== hw/rtl/plt_checker.sv =====
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks of the prime lister, bound to the top level.
// ----------------------------------------------------------------------------
module plt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [plt_pkg::VAL_W-1:0] prime_value_o,
  input logic                      last_o
);

  logic [plt_pkg::VAL_W-1:0] prev_q;

  // Track the last prime delivered in the current request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      prev_q <= last_o ? '0 : prime_value_o;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(prime_value_o) && $stable(last_o))
    else $error("stalled result changed");

  // Every result is an odd number within range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> prime_value_o[0] && (prime_value_o >= plt_pkg::SEED_THREE) &&
      (prime_value_o <= plt_pkg::MAX_LIMIT))
    else $error("result out of range");

  // Primes of one request rise strictly
  a_ascend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (prev_q != '0) |-> prime_value_o > prev_q)
    else $error("primes not ascending");

  // A taken request closes the input until its work is done
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // The first prime of a request is three
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (prev_q == '0) |-> prime_value_o == plt_pkg::SEED_THREE)
    else $error("first prime is not three");

endmodule

bind prime_list_trial_division plt_checker u_plt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .prime_value_o (prime_value_o),
  .last_o        (last_o)
);
